>>> sv/bgu_pkg.sv
`timescale 1ns / 1ps
// bgu_pkg: shared types, codes and defaults of the bilinear grid upsampler
// used by the core, controller, datapath and testbench; depends on nothing

package bgu_pkg;

  localparam int DATA_W = 16;
  localparam int OUT_W  = 24;
  localparam int IDX_W  = 10;
  localparam int DIM_W  = 11;
  localparam int SCL_W  = 5;
  localparam int ST_W   = 2;
  localparam int FRAC_W = 8;

  localparam int LO_COLS_MAX_DEF = 64;
  localparam int LO_ROWS_MAX_DEF = 64;
  localparam int FACTOR_MAX_DEF  = 16;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] REG_SCALE   = 2'd0;
  localparam logic [1:0] REG_HI_COLS = 2'd1;
  localparam logic [1:0] REG_HI_ROWS = 2'd2;
  localparam logic [1:0] REG_MISSING = 2'd3;

  localparam logic [SCL_W-1:0] SCALE_RST   = 5'd2;
  localparam logic [DIM_W-1:0] HI_COLS_RST = 11'd128;
  localparam logic [DIM_W-1:0] HI_ROWS_RST = 11'd128;

  typedef struct packed {
    logic [SCL_W-1:0]         scale_factor;
    logic [DIM_W-1:0]         hi_cols;
    logic [DIM_W-1:0]         hi_rows;
    logic signed [DATA_W-1:0] missing_value;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_COL,
    DIV_ROW,
    DIV_SUM
  } div_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_XGO,
    S_XW,
    S_YGO,
    S_YW,
    S_RD,
    S_MUL,
    S_ACC,
    S_SGO,
    S_SW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     cap;
    logic     wr;
    logic     div_start;
    div_src_t div_src;
    logic     save_x;
    logic     save_y;
    logic     acc_clr;
    logic     rd;
    logic     mul;
    logic     acc_add;
    logic [1:0] corner;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic oog;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

>>> sv/bilinear_grid_upsampler_core.sv
`timescale 1ns / 1ps
// bilinear_grid_upsampler_core: top level, config registers and apb port
// depends on bgu_pkg, bgu_ctrl, bgu_dp
//
// usage:
// - input channel (in_valid/in_stall) carries action, col, row, sample
// - a write request (action 0) stores one low-res cell, no result
// - an interpolation request (action 1) yields one result (interp_value, status)
// - a request is served by the bit-serial divider, which is used three
//   times: col/f, row/f and the weighted sum over f*f
// - the next request is taken in the cycle after the result is loaded
// - a request outside the high-res grid skips the divider and goes from the check state to the result
// - the four corners are read one after another from the single-port store
// - the result sits in an output register; a new request is accepted
//   while it waits, and the next result waits until out_stall drops
// - synchronous reset clears control and restores register defaults;
//   the store holds no defined data until written
// - config writes through the apb port only while the block is idle

module bilinear_grid_upsampler_core #(
  parameter int LO_COLS_MAX = bgu_pkg::LO_COLS_MAX_DEF,
  parameter int LO_ROWS_MAX = bgu_pkg::LO_ROWS_MAX_DEF,
  parameter int FACTOR_MAX  = bgu_pkg::FACTOR_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [bgu_pkg::IDX_W-1:0]         col,
  input  logic [bgu_pkg::IDX_W-1:0]         row,
  input  logic signed [bgu_pkg::DATA_W-1:0] sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bgu_pkg::OUT_W-1:0]  interp_value,
  output logic [bgu_pkg::ST_W-1:0]          status
);

  bgu_pkg::cfg_t cfg;
  bgu_pkg::cmd_t cmd;
  bgu_pkg::sts_t sts;
  logic          wr_req;

  assign pready = 1'b1;
  assign wr_req = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_factor  <= bgu_pkg::SCALE_RST;
      cfg.hi_cols       <= bgu_pkg::HI_COLS_RST;
      cfg.hi_rows       <= bgu_pkg::HI_ROWS_RST;
      cfg.missing_value <= '0;
    end else if (wr_req) begin
      unique case (paddr[3:2])
        bgu_pkg::REG_SCALE:   cfg.scale_factor  <= pwdata[bgu_pkg::SCL_W-1:0];
        bgu_pkg::REG_HI_COLS: cfg.hi_cols       <= pwdata[bgu_pkg::DIM_W-1:0];
        bgu_pkg::REG_HI_ROWS: cfg.hi_rows       <= pwdata[bgu_pkg::DIM_W-1:0];
        bgu_pkg::REG_MISSING: cfg.missing_value <= $signed(pwdata[bgu_pkg::DATA_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bgu_pkg::REG_SCALE:   prdata = 32'(cfg.scale_factor);
      bgu_pkg::REG_HI_COLS: prdata = 32'(cfg.hi_cols);
      bgu_pkg::REG_HI_ROWS: prdata = 32'(cfg.hi_rows);
      bgu_pkg::REG_MISSING: prdata = 32'($unsigned(cfg.missing_value));
      default:              prdata = '0;
    endcase
  end

  bgu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bgu_dp #(
    .LO_COLS_MAX (LO_COLS_MAX),
    .LO_ROWS_MAX (LO_ROWS_MAX),
    .FACTOR_MAX  (FACTOR_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .col          (col),
    .row          (row),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .interp_value (interp_value),
    .status       (status)
  );

endmodule

>>> sv/bgu_ram.sv
`timescale 1ns / 1ps
// bgu_ram: generic single-port ram with registered read
// standalone, no dependencies

module bgu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/bgu_div.sv
`timescale 1ns / 1ps
// bgu_div: bit-serial restoring unsigned divider, one quotient bit per cycle
// standalone, no dependencies

module bgu_div #(
  parameter int NW = 34,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/bgu_ctrl.sv
`timescale 1ns / 1ps
// bgu_ctrl: sequencer of the upsampler, issues datapath commands
// depends on bgu_pkg

module bgu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          action,
  output logic          in_stall,
  input  bgu_pkg::sts_t sts,
  output bgu_pkg::cmd_t cmd
);

  bgu_pkg::state_t state, state_next;
  logic [1:0] corner, corner_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bgu_pkg::S_IDLE;
      corner <= '0;
    end else begin
      state  <= state_next;
      corner <= corner_next;
    end
  end

  always_comb begin
    state_next  = state;
    corner_next = corner;
    unique case (state)
      bgu_pkg::S_IDLE: begin
        if (in_valid && action == bgu_pkg::ACT_REQUEST) begin
          state_next = bgu_pkg::S_CHK;
        end
      end
      bgu_pkg::S_CHK: begin
        corner_next = '0;
        state_next  = sts.oog ? bgu_pkg::S_DONE : bgu_pkg::S_XGO;
      end
      bgu_pkg::S_XGO: state_next = bgu_pkg::S_XW;
      bgu_pkg::S_XW:  if (!sts.div_busy) state_next = bgu_pkg::S_YGO;
      bgu_pkg::S_YGO: state_next = bgu_pkg::S_YW;
      bgu_pkg::S_YW:  if (!sts.div_busy) state_next = bgu_pkg::S_RD;
      bgu_pkg::S_RD:  state_next = bgu_pkg::S_MUL;
      bgu_pkg::S_MUL: state_next = bgu_pkg::S_ACC;
      bgu_pkg::S_ACC: begin
        corner_next = corner + 2'd1;
        state_next  = (corner == 2'd3) ? bgu_pkg::S_SGO : bgu_pkg::S_RD;
      end
      bgu_pkg::S_SGO: state_next = bgu_pkg::S_SW;
      bgu_pkg::S_SW:  if (!sts.div_busy) state_next = bgu_pkg::S_DONE;
      bgu_pkg::S_DONE: if (sts.out_free) state_next = bgu_pkg::S_IDLE;
      default: state_next = bgu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.corner = corner;
    cmd.div_src = bgu_pkg::DIV_COL;
    in_stall   = (state != bgu_pkg::S_IDLE);
    unique case (state)
      bgu_pkg::S_IDLE: begin
        cmd.wr  = in_valid && action == bgu_pkg::ACT_WRITE;
        cmd.cap = in_valid && action == bgu_pkg::ACT_REQUEST;
      end
      bgu_pkg::S_CHK: cmd.acc_clr = 1'b1;
      bgu_pkg::S_XGO: cmd.div_start = 1'b1;
      bgu_pkg::S_XW:  cmd.save_x = !sts.div_busy;
      bgu_pkg::S_YGO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = bgu_pkg::DIV_ROW;
      end
      bgu_pkg::S_YW:  cmd.save_y = !sts.div_busy;
      bgu_pkg::S_RD:  cmd.rd = 1'b1;
      bgu_pkg::S_MUL: cmd.mul = 1'b1;
      bgu_pkg::S_ACC: cmd.acc_add = 1'b1;
      bgu_pkg::S_SGO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = bgu_pkg::DIV_SUM;
      end
      bgu_pkg::S_SW:   cmd.div_src = bgu_pkg::DIV_SUM;
      bgu_pkg::S_DONE: begin
        cmd.div_src  = bgu_pkg::DIV_SUM;
        cmd.res_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/bgu_dp.sv
`timescale 1ns / 1ps
// bgu_dp: datapath with low-res store, corner blend, shared divider, output register
// depends on bgu_pkg, bgu_ram, bgu_div

module bgu_dp #(
  parameter int LO_COLS_MAX = bgu_pkg::LO_COLS_MAX_DEF,
  parameter int LO_ROWS_MAX = bgu_pkg::LO_ROWS_MAX_DEF,
  parameter int FACTOR_MAX  = bgu_pkg::FACTOR_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bgu_pkg::cfg_t                     cfg,
  input  bgu_pkg::cmd_t                     cmd,
  output bgu_pkg::sts_t                     sts,
  input  logic [bgu_pkg::IDX_W-1:0]         col,
  input  logic [bgu_pkg::IDX_W-1:0]         row,
  input  logic signed [bgu_pkg::DATA_W-1:0] sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bgu_pkg::OUT_W-1:0]  interp_value,
  output logic [bgu_pkg::ST_W-1:0]          status
);

  localparam int DEPTH = LO_COLS_MAX * LO_ROWS_MAX;
  localparam int AWID  = $clog2(DEPTH);
  localparam int FW    = $clog2(FACTOR_MAX + 1);
  localparam int WW    = $clog2(FACTOR_MAX * FACTOR_MAX + 1);
  localparam int AW    = bgu_pkg::DATA_W + WW + 1;
  localparam int NW    = AW + bgu_pkg::FRAC_W;
  localparam int DIM_W = bgu_pkg::DIM_W;
  localparam int LW    = DIM_W + FW;

  logic [FW-1:0]   f;
  logic [2*FW-1:0] fsq;
  logic [bgu_pkg::IDX_W-1:0] col_r, row_r, rx0, ry0;
  logic [FW-1:0]   remx, remy;
  logic            oog_r, miss_r, inr_r;
  logic [WW-1:0]   w_r;
  logic signed [AW-1:0] prod_r, acc, pm;
  logic [AW-1:0]   mag;
  logic signed [bgu_pkg::DATA_W-1:0] v;
  logic [bgu_pkg::DATA_W-1:0] rdata;

  logic [NW-1:0] div_n, quo;
  logic [WW-1:0] div_d, rem;
  logic          div_busy;

  logic            dx, dy;
  logic [DIM_W-1:0] cx, cy;
  logic [LW-1:0]   xlim, ylim;
  logic            in_range;
  logic [FW-1:0]   wx, wy;
  logic [2*FW-1:0] wprod;

  logic            wr_ok, we;
  logic [AWID-1:0] addr;
  logic [bgu_pkg::OUT_W-1:0] q24, res;

  always_comb begin
    if (cfg.scale_factor == '0) begin
      f = FW'(1);
    end else if (8'(cfg.scale_factor) > 8'(FACTOR_MAX)) begin
      f = FW'(FACTOR_MAX);
    end else begin
      f = FW'(cfg.scale_factor);
    end
  end
  assign fsq = f * f;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      col_r  <= col;
      row_r  <= row;
      oog_r  <= ({1'b0, col} >= cfg.hi_cols) || ({1'b0, row} >= cfg.hi_rows);
      miss_r <= 1'b0;
    end else if (cmd.mul && inr_r && $signed(rdata) == cfg.missing_value) begin
      miss_r <= 1'b1;
    end
  end

  // divider operand selection
  always_comb begin
    mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
    case (cmd.div_src)
      bgu_pkg::DIV_COL: begin
        div_n = NW'(col_r);
        div_d = WW'(f);
      end
      bgu_pkg::DIV_ROW: begin
        div_n = NW'(row_r);
        div_d = WW'(f);
      end
      default: begin
        div_n = {mag, {bgu_pkg::FRAC_W{1'b0}}};
        div_d = WW'(fsq);
      end
    endcase
  end

  bgu_div #(.NW(NW), .DW(WW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.save_x) begin
      rx0  <= quo[bgu_pkg::IDX_W-1:0];
      remx <= rem[FW-1:0];
    end
    if (cmd.save_y) begin
      ry0  <= quo[bgu_pkg::IDX_W-1:0];
      remy <= rem[FW-1:0];
    end
  end

  // corner geometry
  assign dx   = cmd.corner[1];
  assign dy   = cmd.corner[0];
  assign cx   = DIM_W'({1'b0, rx0}) + DIM_W'(dx);
  assign cy   = DIM_W'({1'b0, ry0}) + DIM_W'(dy);
  assign xlim = LW'(cx + DIM_W'(1)) * LW'(f);
  assign ylim = LW'(cy + DIM_W'(1)) * LW'(f);
  assign in_range = (cx < DIM_W'(LO_COLS_MAX)) && (cy < DIM_W'(LO_ROWS_MAX)) &&
                    (xlim <= LW'(cfg.hi_cols)) && (ylim <= LW'(cfg.hi_rows));
  assign wx    = dx ? remx : FW'(f - remx);
  assign wy    = dy ? remy : FW'(f - remy);
  assign wprod = wx * wy;

  // store access
  assign wr_ok = ({1'b0, col} < DIM_W'(LO_COLS_MAX)) && ({1'b0, row} < DIM_W'(LO_ROWS_MAX));
  assign we    = cmd.wr && wr_ok;
  assign addr  = cmd.wr ? AWID'(int'(row) * LO_COLS_MAX + int'(col))
                        : AWID'(int'(cy) * LO_COLS_MAX + int'(cx));

  bgu_ram #(.WIDTH(bgu_pkg::DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (sample),
    .rdata (rdata)
  );

  assign v  = inr_r ? $signed(rdata) : cfg.missing_value;
  assign pm = v * $signed({1'b0, w_r});

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      w_r   <= WW'(wprod);
      inr_r <= in_range;
    end
    if (cmd.mul) begin
      prod_r <= pm;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + prod_r;
    end
  end

  assign q24 = quo[bgu_pkg::OUT_W-1:0];
  assign res = acc[AW-1] ? bgu_pkg::OUT_W'(-q24) : q24;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (oog_r) begin
        interp_value <= '0;
        status       <= bgu_pkg::ST_OUTSIDE;
      end else if (miss_r) begin
        interp_value <= {cfg.missing_value, {bgu_pkg::FRAC_W{1'b0}}};
        status       <= bgu_pkg::ST_MISSING;
      end else begin
        interp_value <= res;
        status       <= bgu_pkg::ST_OK;
      end
    end
  end

  assign sts.oog      = oog_r;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

>>> tb/upsample_checker.sv
`timescale 1ns / 1ps
// upsample_checker: watches the request and result channels of the upsampler,
// predicts each interpolated cell and compares; depends on bgu_pkg

module upsample_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_idx,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              action,
  input  logic [bgu_pkg::IDX_W-1:0]         col,
  input  logic [bgu_pkg::IDX_W-1:0]         row,
  input  logic signed [bgu_pkg::DATA_W-1:0] sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [bgu_pkg::OUT_W-1:0]  interp_value,
  input  logic [bgu_pkg::ST_W-1:0]          status,
  output int                                errors,
  output int                                pending
);

  typedef struct packed {
    logic signed [bgu_pkg::OUT_W-1:0] value;
    logic [bgu_pkg::ST_W-1:0]         st;
  } cell_res_t;

  logic [bgu_pkg::SCL_W-1:0]         m_scale;
  logic [bgu_pkg::DIM_W-1:0]         m_cols;
  logic [bgu_pkg::DIM_W-1:0]         m_rows;
  logic signed [bgu_pkg::DATA_W-1:0] m_miss;
  logic signed [bgu_pkg::DATA_W-1:0] grid [bgu_pkg::LO_COLS_MAX_DEF*bgu_pkg::LO_ROWS_MAX_DEF];
  cell_res_t                         expected_cells [$];

  function automatic logic corner(input int cx, input int cy, input int lc, input int lr,
                                  output longint v);
    if (cx < lc && cy < lr) begin
      v = grid[cy*bgu_pkg::LO_COLS_MAX_DEF+cx];
      return grid[cy*bgu_pkg::LO_COLS_MAX_DEF+cx] != m_miss;
    end
    v = m_miss;
    return 1'b1;
  endfunction

  function automatic cell_res_t interpolate(input int c, input int r);
    cell_res_t o;
    int f, lc, lr, rx, ry, x0, y0;
    longint a, b, d, e, s;
    logic ok;
    if (c >= m_cols || r >= m_rows) begin
      o.value = '0;
      o.st = bgu_pkg::ST_OUTSIDE;
      return o;
    end
    f = (m_scale == 0) ? 1 :
        (m_scale > bgu_pkg::FACTOR_MAX_DEF ? bgu_pkg::FACTOR_MAX_DEF : m_scale);
    lc = m_cols / f;
    lr = m_rows / f;
    if (lc > bgu_pkg::LO_COLS_MAX_DEF) lc = bgu_pkg::LO_COLS_MAX_DEF;
    if (lr > bgu_pkg::LO_ROWS_MAX_DEF) lr = bgu_pkg::LO_ROWS_MAX_DEF;
    rx = c / f;
    ry = r / f;
    x0 = rx * f;
    y0 = ry * f;
    ok = corner(rx, ry, lc, lr, a);
    ok = corner(rx, ry+1, lc, lr, b) && ok;
    ok = corner(rx+1, ry, lc, lr, d) && ok;
    ok = corner(rx+1, ry+1, lc, lr, e) && ok;
    if (!ok) begin
      o.value = bgu_pkg::OUT_W'(longint'(m_miss) * 256);
      o.st = bgu_pkg::ST_MISSING;
      return o;
    end
    s = a*(x0+f-c)*(y0+f-r) + d*(c-x0)*(y0+f-r) + b*(x0+f-c)*(r-y0) + e*(c-x0)*(r-y0);
    o.value = bgu_pkg::OUT_W'((s * 256) / (f * f));
    o.st = bgu_pkg::ST_OK;
    return o;
  endfunction

  always @(posedge clk) begin
    cell_res_t w;
    if (rst) begin
      m_scale <= bgu_pkg::SCALE_RST;
      m_cols <= bgu_pkg::HI_COLS_RST;
      m_rows <= bgu_pkg::HI_ROWS_RST;
      m_miss <= '0;
      errors <= 0;
      pending <= 0;
      expected_cells.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          bgu_pkg::REG_SCALE:   m_scale <= cfg_data[bgu_pkg::SCL_W-1:0];
          bgu_pkg::REG_HI_COLS: m_cols <= cfg_data[bgu_pkg::DIM_W-1:0];
          bgu_pkg::REG_HI_ROWS: m_rows <= cfg_data[bgu_pkg::DIM_W-1:0];
          bgu_pkg::REG_MISSING: m_miss <= cfg_data[bgu_pkg::DATA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (action == bgu_pkg::ACT_WRITE) begin
          if (col < bgu_pkg::LO_COLS_MAX_DEF && row < bgu_pkg::LO_ROWS_MAX_DEF)
            grid[row*bgu_pkg::LO_COLS_MAX_DEF+col] = sample;
        end else begin
          expected_cells.insert(expected_cells.size(), interpolate(col, row));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          if (errors < 10) $display("unexpected result %0d/%0d", interp_value, status);
          errors <= errors + 1;
        end else begin
          w = expected_cells.pop_front();
          if (w.value !== interp_value || w.st !== status) begin
            if (errors < 10)
              $display("mismatch: expected %0d/%0d got %0d/%0d",
                       w.value, w.st, interp_value, status);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_cells.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: drives config writes and cell requests into bilinear_grid_upsampler_core
// with random idling; depends on bgu_pkg and upsample_checker

module tb;

  localparam int FILL_N = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic action = 1'b0;
  logic [bgu_pkg::IDX_W-1:0] col = '0, row = '0;
  logic signed [bgu_pkg::DATA_W-1:0] sample = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [bgu_pkg::OUT_W-1:0] interp_value;
  logic [bgu_pkg::ST_W-1:0] status;
  int errors, pending;
  int send_idle = 0, recv_idle = 0;
  int quiet = 0;
  logic [bgu_pkg::SCL_W-1:0] cur_f = bgu_pkg::SCALE_RST;
  logic [bgu_pkg::DIM_W-1:0] cur_c = bgu_pkg::HI_COLS_RST, cur_r = bgu_pkg::HI_ROWS_RST;
  logic written [bgu_pkg::LO_COLS_MAX_DEF*bgu_pkg::LO_ROWS_MAX_DEF];

  always #5 clk = ~clk;

  bilinear_grid_upsampler_core uut (.*);

  upsample_checker chk (
    .clk, .rst,
    .cfg_we(psel && penable && pwrite && pready), .cfg_idx(paddr[3:2]), .cfg_data(pwdata),
    .in_valid, .in_stall, .action, .col, .row, .sample,
    .out_valid, .out_stall, .interp_value, .status, .errors, .pending
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send(input logic a, input int c, input int r, input int s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; action <= a;
    col <= bgu_pkg::IDX_W'(c); row <= bgu_pkg::IDX_W'(r); sample <= bgu_pkg::DATA_W'(s);
    if (a == bgu_pkg::ACT_WRITE && c < bgu_pkg::LO_COLS_MAX_DEF &&
        r < bgu_pkg::LO_ROWS_MAX_DEF)
      written[r*bgu_pkg::LO_COLS_MAX_DEF+c] = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic setup(input int f, input int hc, input int hr, input int m);
    drain();
    reg_write(bgu_pkg::REG_SCALE, f); reg_write(bgu_pkg::REG_HI_COLS, hc);
    reg_write(bgu_pkg::REG_HI_ROWS, hr); reg_write(bgu_pkg::REG_MISSING, m);
    cur_f = bgu_pkg::SCL_W'(f); cur_c = bgu_pkg::DIM_W'(hc); cur_r = bgu_pkg::DIM_W'(hr);
  endtask

  // fill a corner block; requests only touch cells that were written
  task automatic fill(input int m);
    for (int y = 0; y < FILL_N; y++)
      for (int x = 0; x < FILL_N; x++)
        send(bgu_pkg::ACT_WRITE, x, y, ($urandom_range(19) == 0) ? m : $urandom);
  endtask

  function automatic logic reads_ok(input int c, input int r);
    int f, lc, lr, rx, ry;
    logic ok;
    if (c >= cur_c || r >= cur_r) return 1'b1;
    f = (cur_f == 0) ? 1 :
        (cur_f > bgu_pkg::FACTOR_MAX_DEF ? bgu_pkg::FACTOR_MAX_DEF : cur_f);
    lc = cur_c / f;
    lr = cur_r / f;
    if (lc > bgu_pkg::LO_COLS_MAX_DEF) lc = bgu_pkg::LO_COLS_MAX_DEF;
    if (lr > bgu_pkg::LO_ROWS_MAX_DEF) lr = bgu_pkg::LO_ROWS_MAX_DEF;
    rx = c / f;
    ry = r / f;
    ok = 1'b1;
    for (int dy = 0; dy < 2; dy++)
      for (int dx = 0; dx < 2; dx++)
        if (rx + dx < lc && ry + dy < lr &&
            !written[(ry+dy)*bgu_pkg::LO_COLS_MAX_DEF+rx+dx])
          ok = 1'b0;
    return ok;
  endfunction

  task automatic rand_req;
    int c, r, tries;
    tries = 0;
    do begin
      c = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(cur_c);
      r = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(cur_r);
      if (c > 1023) c = 1023;
      if (r > 1023) r = 1023;
      tries++;
    end while (!reads_ok(c, r) && tries < 64);
    if (!reads_ok(c, r)) begin
      c = 0;
      r = 0;
    end
    send(bgu_pkg::ACT_REQUEST, c, r, $urandom);
  endtask

  initial begin
    foreach (written[i]) written[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    setup(2, 128, 128, 0);
    fill(0);
    drain();
    send(bgu_pkg::ACT_WRITE, 1023, 1023, 16'h7fff);
    send(bgu_pkg::ACT_WRITE, 5, 5, -32768);
    send(bgu_pkg::ACT_WRITE, 6, 5, 32767);
    send(bgu_pkg::ACT_WRITE, 5, 6, 32767);
    send(bgu_pkg::ACT_WRITE, 6, 6, -32768);
    send(bgu_pkg::ACT_WRITE, 63, 63, 12345);
    send(bgu_pkg::ACT_WRITE, 32, 0, -777);
    send(bgu_pkg::ACT_WRITE, 33, 0, 4321);
    send(bgu_pkg::ACT_WRITE, 32, 1, 32767);
    send(bgu_pkg::ACT_WRITE, 33, 1, -32768);
    send(bgu_pkg::ACT_REQUEST, 11, 11, 0);
    send(bgu_pkg::ACT_REQUEST, 0, 0, 0);
    send(bgu_pkg::ACT_REQUEST, 127, 127, 0);
    send(bgu_pkg::ACT_REQUEST, 128, 0, 0);
    send(bgu_pkg::ACT_REQUEST, 0, 1023, 0);
    send(bgu_pkg::ACT_REQUEST, 1023, 1023, 0);
    setup(0, 1024, 1024, -32768);
    send(bgu_pkg::ACT_REQUEST, 63, 63, 0);
    send(bgu_pkg::ACT_REQUEST, 1023, 0, 0);
    setup(31, 1, 1, 32767);
    send(bgu_pkg::ACT_REQUEST, 0, 0, 0);
    setup(16, 1024, 1024, 32767);
    send(bgu_pkg::ACT_REQUEST, 1023, 1023, 0);
    send(bgu_pkg::ACT_REQUEST, 517, 3, 0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 14 : (ph == 1 ? 88 : 0);
      recv_idle = (ph == 0) ? 88 : (ph == 1 ? 14 : 0);
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(3))
          0: setup($urandom_range(1, 16), $urandom_range(1, 1024), $urandom_range(1, 1024),
                   $urandom_range(65535));
          1: setup($urandom_range(1, 4), $urandom_range(2, 200), $urandom_range(2, 200),
                   $urandom_range(65535));
          2: setup($urandom_range(17, 31), $urandom_range(1, 1024), $urandom_range(1, 1024),
                   $urandom_range(65535));
          default: setup($urandom_range(2), $urandom_range(1, 64), $urandom_range(1, 64),
                         $urandom_range(65535));
        endcase
        for (int i = 0; i < 65; i++) begin
          if ($urandom_range(3) == 0)
            send(bgu_pkg::ACT_WRITE, $urandom_range(70), $urandom_range(70), $urandom);
          else rand_req();
          if (i == 40) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
          end
        end
      end
    end
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> bilinear_grid_upsampler_core.f
sv/bgu_pkg.sv
sv/bgu_ram.sv
sv/bgu_div.sv
sv/bgu_ctrl.sv
sv/bgu_dp.sv
sv/bilinear_grid_upsampler_core.sv
tb/upsample_checker.sv
tb/tb.sv
